// File: hdl/cmme_pkg.sv
package cmme_pkg;

  localparam int FRAC_BITS   = 4;
  localparam int MEAN_W      = 16;
  localparam int SIGMA_W     = 12;
  localparam int THR_W       = 4;
  localparam int VAL_W       = 17;
  localparam int ROW_W       = 5;
  localparam int KEPT_W      = 6;
  localparam int OUT_TDATA_W = 56;
  localparam int DIFF_MAX    = 65535;

  localparam logic [THR_W-1:0] THR_RESET = 4'd5;

  // One classified channel as it travels from the front end to the sorters.
  typedef struct packed {
    logic                    keep_high;
    logic signed [VAL_W-1:0] val_high;
    logic                    keep_low;
    logic signed [VAL_W-1:0] val_low;
    logic                    last;
    logic [ROW_W-1:0]        row;
  } item_t;

endpackage

// File: hdl/common_mode_median_estimator.sv
// Common-mode median estimator: one channel per transfer, one result per row.
// A row result goes through the queue, the sorters and an output register.
// Throughput: one channel per cycle unless the output stalls; sorters insert kept
// channels; a finished row is read out by the cycle the next row starts filling.
// A stalled output backs up through a 4-entry queue, then in_tready drops.
// Reset (rst_n, synchronous, active low): counters and queue cleared, threshold = 5.
module common_mode_median_estimator #(
  parameter int SAMPLE_BITS      = 12,
  parameter int CHANNELS_PER_ROW = 32,
  parameter int ROWS_PER_EVENT   = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [cmme_pkg::THR_W-1:0]       cfg_wr_data,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // high_sample, high_ped_mean, high_ped_sigma, low_sample, low_ped_mean,
  // low_ped_sigma, zero fill
  input  logic [((2*SAMPLE_BITS+56+7)/8)*8-1:0] in_tdata,
  // masked
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // row_number, median_high, median_low, kept_high, kept_low, zero fill
  output logic [cmme_pkg::OUT_TDATA_W-1:0] out_tdata
);

  localparam int SB = SAMPLE_BITS;

  logic [cmme_pkg::THR_W-1:0] thr_r;
  logic                       acc, q_full, q_valid, q_pop;
  cmme_pkg::item_t            f_item, q_item;

  always_ff @(posedge clk) begin
    if (!rst_n)
      thr_r <= cmme_pkg::THR_RESET;
    else if (cfg_wr_en)
      thr_r <= cfg_wr_data;
  end

  assign in_tready = !q_full;
  assign acc       = in_tvalid && in_tready;

  cmme_front #(
    .SAMPLE_BITS      (SAMPLE_BITS),
    .CHANNELS_PER_ROW (CHANNELS_PER_ROW),
    .ROWS_PER_EVENT   (ROWS_PER_EVENT)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .acc            (acc),
    .thr            (thr_r),
    .high_sample    (in_tdata[SB-1:0]),
    .high_ped_mean  (in_tdata[SB+15:SB]),
    .high_ped_sigma (in_tdata[SB+27:SB+16]),
    .low_sample     (in_tdata[2*SB+27:SB+28]),
    .low_ped_mean   (in_tdata[2*SB+43:2*SB+28]),
    .low_ped_sigma  (in_tdata[2*SB+55:2*SB+44]),
    .masked         (in_tuser),
    .item           (f_item)
  );

  cmme_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (acc),
    .push_item  (f_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_item  (q_item)
  );

  cmme_back #(.CHANNELS_PER_ROW(CHANNELS_PER_ROW)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_valid),
    .head_item  (q_item),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// File: hdl/cmme_front.sv
module cmme_front #(
  parameter int SAMPLE_BITS      = 12,
  parameter int CHANNELS_PER_ROW = 32,
  parameter int ROWS_PER_EVENT   = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          acc,
  input  logic [cmme_pkg::THR_W-1:0]    thr,
  input  logic [SAMPLE_BITS-1:0]        high_sample,
  input  logic [cmme_pkg::MEAN_W-1:0]   high_ped_mean,
  input  logic [cmme_pkg::SIGMA_W-1:0]  high_ped_sigma,
  input  logic [SAMPLE_BITS-1:0]        low_sample,
  input  logic [cmme_pkg::MEAN_W-1:0]   low_ped_mean,
  input  logic [cmme_pkg::SIGMA_W-1:0]  low_ped_sigma,
  input  logic                          masked,
  output cmme_pkg::item_t               item
);

  localparam int SW  = SAMPLE_BITS + cmme_pkg::FRAC_BITS;
  localparam int DW  = ((SW > cmme_pkg::MEAN_W) ? SW : cmme_pkg::MEAN_W) + 1;
  localparam int CIW = $clog2(CHANNELS_PER_ROW);
  localparam int RW  = (ROWS_PER_EVENT > 1) ? $clog2(ROWS_PER_EVENT) : 1;
  localparam int LW  = cmme_pkg::THR_W + cmme_pkg::SIGMA_W;
  localparam int VW  = cmme_pkg::VAL_W;

  localparam logic signed [DW-1:0] SAT_HI = DW'(cmme_pkg::DIFF_MAX);
  localparam logic signed [DW-1:0] SAT_LO = -DW'(cmme_pkg::DIFF_MAX);
  localparam logic [CIW-1:0]       CH_LAST = CIW'(CHANNELS_PER_ROW - 1);
  localparam logic [RW-1:0]        ROW_LAST = RW'(ROWS_PER_EVENT - 1);

  logic [CIW-1:0] chan_r, chan_nxt;
  logic [RW-1:0]  row_r, row_nxt;
  logic           is_last;

  // Pedestal subtraction with saturation, then the strict sigma cut.
  function automatic logic [VW:0] classify(input logic [SAMPLE_BITS-1:0]       s,
                                           input logic [cmme_pkg::MEAN_W-1:0]  m,
                                           input logic [cmme_pkg::SIGMA_W-1:0] sg,
                                           input logic [cmme_pkg::THR_W-1:0]   t);
    logic signed [DW-1:0] d;
    logic signed [VW-1:0] v;
    logic [LW-1:0]        lim;
    logic                 k;
    d = $signed(DW'({s, {cmme_pkg::FRAC_BITS{1'b0}}}) - DW'(m));
    if (d > SAT_HI)
      v = VW'(cmme_pkg::DIFF_MAX);
    else if (d < SAT_LO)
      v = -VW'(cmme_pkg::DIFF_MAX);
    else
      v = d[VW-1:0];
    lim = LW'(t) * LW'(sg);
    k = $signed({v[VW-1], v}) < $signed({2'b00, lim});
    return {k, v};
  endfunction

  assign is_last = (chan_r == CH_LAST);

  always_comb begin
    logic [VW:0] ch;
    logic [VW:0] cl;
    ch = classify(high_sample, high_ped_mean, high_ped_sigma, thr);
    cl = classify(low_sample, low_ped_mean, low_ped_sigma, thr);
    item.keep_high = ch[VW] & ~masked;
    item.val_high  = ch[VW-1:0];
    item.keep_low  = cl[VW] & ~masked;
    item.val_low   = cl[VW-1:0];
    item.last      = is_last;
    item.row       = cmme_pkg::ROW_W'(row_r);
  end

  always_comb begin
    chan_nxt = chan_r;
    row_nxt  = row_r;
    if (acc) begin
      if (is_last) begin
        chan_nxt = '0;
        row_nxt  = (row_r == ROW_LAST) ? '0 : row_r + RW'(1);
      end else begin
        chan_nxt = chan_r + CIW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_r <= '0;
      row_r  <= '0;
    end else begin
      chan_r <= chan_nxt;
      row_r  <= row_nxt;
    end
  end

endmodule

// File: hdl/cmme_queue.sv
module cmme_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  cmme_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output cmme_pkg::item_t head_item
);

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  cmme_pkg::item_t   mem_r [DEPTH];
  logic [PW-1:0]     wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;

  assign full       = (cnt_r == CW'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_item  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + PW'(1) : wp_r;
    rp_nxt  = pop ? rp_r + PW'(1) : rp_r;
    cnt_nxt = cnt_r;
    if (push && !pop)
      cnt_nxt = cnt_r + CW'(1);
    else if (pop && !push)
      cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push)
      mem_r[wp_r] <= push_item;
  end

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != '0)
    else $error("queue popped while empty");

endmodule

// File: hdl/cmme_sorter.sv
module cmme_sorter #(
  parameter int CHANNELS_PER_ROW = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                clr,
  input  logic                                ins,
  input  logic signed [cmme_pkg::VAL_W-1:0]   val,
  output logic [$clog2(CHANNELS_PER_ROW+1)-1:0] count,
  output logic signed [cmme_pkg::VAL_W-1:0]   median
);

  localparam int CW = $clog2(CHANNELS_PER_ROW + 1);
  localparam int IW = $clog2(CHANNELS_PER_ROW);
  localparam int VW = cmme_pkg::VAL_W;

  logic signed [VW-1:0] list_r [CHANNELS_PER_ROW];
  logic signed [VW-1:0] list_nxt [CHANNELS_PER_ROW];
  logic [CW-1:0]        cnt_r, cnt_nxt, base;
  logic [CHANNELS_PER_ROW-1:0] gt;
  logic                 room;
  logic [CW-1:0]        half;

  // A clear restarts the row; an insert in the same cycle lands in an empty list.
  assign base = clr ? '0 : cnt_r;
  assign room = (base < CW'(CHANNELS_PER_ROW));

  // Each cell compares against the new value; unused cells act as +infinity.
  always_comb begin
    for (int i = 0; i < CHANNELS_PER_ROW; i++) begin
      gt[i] = (CW'(i) >= base) || (list_r[i] > val);
    end
    for (int i = 0; i < CHANNELS_PER_ROW; i++) begin
      if (!gt[i])
        list_nxt[i] = list_r[i];
      else if (i > 0 && gt[(i > 0) ? i - 1 : 0])
        list_nxt[i] = list_r[(i > 0) ? i - 1 : 0];
      else
        list_nxt[i] = val;
    end
  end

  assign cnt_nxt = (ins && room) ? base + CW'(1) : base;

  always_ff @(posedge clk) begin
    if (!rst_n)
      cnt_r <= '0;
    else
      cnt_r <= cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (ins && room) begin
      for (int i = 0; i < CHANNELS_PER_ROW; i++)
        list_r[i] <= list_nxt[i];
    end
  end

  assign half   = cnt_r >> 1;
  assign count  = cnt_r;
  assign median = (cnt_r == '0) ? '0 : list_r[half[IW-1:0]];

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CHANNELS_PER_ROW))
    else $error("sorter count beyond row size");

endmodule

// File: hdl/cmme_back.sv
module cmme_back #(
  parameter int CHANNELS_PER_ROW = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               head_valid,
  input  cmme_pkg::item_t                    head_item,
  output logic                               pop,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [cmme_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  localparam int CW = $clog2(CHANNELS_PER_ROW + 1);
  localparam int VW = cmme_pkg::VAL_W;
  localparam int KW = cmme_pkg::KEPT_W;
  localparam int RW = cmme_pkg::ROW_W;

  logic                 pend_r, pend_nxt;
  logic [RW-1:0]        row_r, row_nxt;
  logic                 ovalid_r, ovalid_nxt;
  logic [cmme_pkg::OUT_TDATA_W-1:0] odata_r;
  logic                 cap;
  logic [CW-1:0]        cnt_h, cnt_l;
  logic signed [VW-1:0] med_h, med_l;

  // The next row starts filling no earlier than the cycle the finished row is read out.
  assign cap = pend_r && (!ovalid_r || out_tready);
  assign pop = head_valid && (!pend_r || cap);

  cmme_sorter #(.CHANNELS_PER_ROW(CHANNELS_PER_ROW)) u_sort_high (
    .clk    (clk),
    .rst_n  (rst_n),
    .clr    (cap),
    .ins    (pop && head_item.keep_high),
    .val    (head_item.val_high),
    .count  (cnt_h),
    .median (med_h)
  );

  cmme_sorter #(.CHANNELS_PER_ROW(CHANNELS_PER_ROW)) u_sort_low (
    .clk    (clk),
    .rst_n  (rst_n),
    .clr    (cap),
    .ins    (pop && head_item.keep_low),
    .val    (head_item.val_low),
    .count  (cnt_l),
    .median (med_l)
  );

  always_comb begin
    pend_nxt   = pend_r;
    row_nxt    = row_r;
    ovalid_nxt = ovalid_r;
    if (cap)
      pend_nxt = 1'b0;
    if (pop && head_item.last) begin
      pend_nxt = 1'b1;
      row_nxt  = head_item.row;
    end
    if (cap)
      ovalid_nxt = 1'b1;
    else if (out_tready)
      ovalid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      pend_r   <= pend_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r <= row_nxt;
    if (cap)
      odata_r <= {5'b0, KW'(cnt_l), KW'(cnt_h), med_l, med_h, row_r};
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;

  a_pop_while_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && pend_r) |-> cap)
    else $error("row started before the previous one was read out");

  a_capture_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cap |=> ovalid_r)
    else $error("captured row not presented");

endmodule
